[src/drtm_pkg.sv]
// Shared types and codes for the dirty rectangle table merger.
package drtm_pkg;

    localparam int unsigned CoordW = 12;
    localparam int unsigned ResW   = 13;
    localparam int unsigned AreaW  = 26;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_MERGE = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_COVERED  = 3'd1;
    localparam logic [2:0] ST_OFFSCR   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;
    localparam logic [2:0] ST_SURVIVOR = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [CoordW-1:0] b;
        logic [CoordW-1:0] r;
        logic [CoordW-1:0] t;
        logic [CoordW-1:0] l;
    } t_box;

    typedef struct packed {
        logic [2:0] status;
        logic       wake;
        t_box       box;
        logic [3:0] slot;
        logic [4:0] total;
        logic       last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CHK,
        S_MRG_D,
        S_MRG_A,
        S_MRG_S,
        S_MRG_B,
        S_MRG_C,
        S_EMIT_S,
        S_EMIT_D,
        S_OUT
    } t_state;

endpackage

[src/drtm_ram.sv]
// Generic single write port, single read port RAM with registered read.
module drtm_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/dirty_rect_table_merger.sv]
// Dirty rectangle table: clip/contain/append, clear, and pairwise merge with survivor output.
// Add scans the stored entries with one RAM read per entry; merge runs a pairwise pass and
// then emits each survivor. The single read port of the rectangle RAM paces both scans.
// One item is worked on at a time.
// Reset: entry count and absorbed flags cleared, width 320, height 240; table RAM undefined.
module dirty_rect_table_merger #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,  // rect_left, rect_top, rect_right, rect_bottom
    input  logic [1:0]  i_s_axis_tuser,  // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // wake_render, out_left, out_top, out_right, out_bottom, entry_slot, entry_total, pad
    output logic [63:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser,  // status
    output logic        o_m_axis_tlast,  // last_result
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned BW = $bits(drtm_pkg::t_box);

    drtm_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_cnt, n_cnt, r_i, n_i, r_d, n_d, r_s, n_s;
    logic [TABLE_DEPTH-1:0] r_flags, n_flags;
    drtm_pkg::t_box r_a, n_a, r_c, n_c, r_j, n_j;
    logic [drtm_pkg::AreaW-1:0] r_pj, r_pa, r_pb, n_pj, n_pa, n_pb;
    logic r_touch, n_touch;
    drtm_pkg::t_res r_res, n_res;
    logic [12:0] r_w, r_h;

    logic        r_m_valid;
    drtm_pkg::t_res r_m;

    logic          mem_we, mem_re;
    logic [IW-1:0] mem_waddr, mem_raddr;
    drtm_pkg::t_box mem_wdata, mem_rdata;

    logic s_acc;
    logic out_free;
    logic [12:0] eff_w, eff_h;
    logic signed [16:0] scr_r, scr_b, in_l, in_t, in_r, in_b, cl, ct, cr, cb;
    logic off_scr;
    drtm_pkg::t_box clip_box, scr_box;
    logic contained, later;
    logic [12:0] ext_jw, ext_jh, ext_aw, ext_ah, ext_bw, ext_bh;

    drtm_ram #(.WIDTH(BW), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_s_axis_tready = (r_state == drtm_pkg::S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // clipping
    always_comb begin
        eff_w = (r_w > 13'd4096) ? 13'd4096 : r_w;
        eff_h = (r_h > 13'd4096) ? 13'd4096 : r_h;
        scr_r = $signed({4'b0, eff_w}) - 17'sd1;
        scr_b = $signed({4'b0, eff_h}) - 17'sd1;
        in_l  = 17'($signed(i_s_axis_tdata[15:0]));
        in_t  = 17'($signed(i_s_axis_tdata[31:16]));
        in_r  = 17'($signed(i_s_axis_tdata[47:32]));
        in_b  = 17'($signed(i_s_axis_tdata[63:48]));
        cl = (in_l < 17'sd0) ? 17'sd0 : in_l;
        ct = (in_t < 17'sd0) ? 17'sd0 : in_t;
        cr = (in_r > scr_r) ? scr_r : in_r;
        cb = (in_b > scr_b) ? scr_b : in_b;
        off_scr = (cl > cr) || (ct > cb);
        clip_box.l = cl[11:0];
        clip_box.t = ct[11:0];
        clip_box.r = cr[11:0];
        clip_box.b = cb[11:0];
        scr_box.l = '0;
        scr_box.t = '0;
        scr_box.r = scr_r[11:0];
        scr_box.b = scr_b[11:0];
    end

    assign contained = (r_c.l >= mem_rdata.l) && (r_c.t >= mem_rdata.t) &&
                       (r_c.r <= mem_rdata.r) && (r_c.b <= mem_rdata.b);

    always_comb begin
        later = 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (!r_flags[k] && (CW'(k) > r_i) && (CW'(k) < r_cnt)) begin
                later = 1'b1;
            end
        end
    end

    // bounding box and areas for one merge candidate
    always_comb begin
        n_j.l = (r_a.l < mem_rdata.l) ? r_a.l : mem_rdata.l;
        n_j.t = (r_a.t < mem_rdata.t) ? r_a.t : mem_rdata.t;
        n_j.r = (r_a.r > mem_rdata.r) ? r_a.r : mem_rdata.r;
        n_j.b = (r_a.b > mem_rdata.b) ? r_a.b : mem_rdata.b;
        n_touch = !((r_a.l > mem_rdata.r) || (mem_rdata.l > r_a.r) ||
                    (r_a.t > mem_rdata.b) || (mem_rdata.t > r_a.b));
        ext_jw = {1'b0, n_j.r} - {1'b0, n_j.l} + 13'd1;
        ext_jh = {1'b0, n_j.b} - {1'b0, n_j.t} + 13'd1;
        ext_aw = {1'b0, r_a.r} - {1'b0, r_a.l} + 13'd1;
        ext_ah = {1'b0, r_a.b} - {1'b0, r_a.t} + 13'd1;
        ext_bw = {1'b0, mem_rdata.r} - {1'b0, mem_rdata.l} + 13'd1;
        ext_bh = {1'b0, mem_rdata.b} - {1'b0, mem_rdata.t} + 13'd1;
        n_pj = ext_jw * ext_jh;
        n_pa = ext_aw * ext_ah;
        n_pb = ext_bw * ext_bh;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_d     = r_d;
        n_s     = r_s;
        n_flags = r_flags;
        n_a     = r_a;
        n_c     = r_c;
        n_res   = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_cnt[IW-1:0];
        mem_wdata = r_c;
        mem_re    = 1'b0;
        mem_raddr = r_i[IW-1:0];
        unique case (r_state)
            drtm_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_res = '0;
                    n_ret = drtm_pkg::S_IDLE;
                    n_i   = '0;
                    n_d   = '0;
                    n_res.last  = 1'b1;
                    n_res.total = 5'(r_cnt);
                    unique case (i_s_axis_tuser)
                        drtm_pkg::KIND_ADD: begin
                            n_c = clip_box;
                            if (off_scr) begin
                                n_res.status = drtm_pkg::ST_OFFSCR;
                                n_state = drtm_pkg::S_OUT;
                            end else begin
                                n_state = drtm_pkg::S_ADD_RD;
                            end
                        end
                        drtm_pkg::KIND_CLEAR: begin
                            n_cnt   = '0;
                            n_flags = '0;
                            n_res.status = drtm_pkg::ST_CLEARED;
                            n_res.total  = '0;
                            n_state = drtm_pkg::S_OUT;
                        end
                        drtm_pkg::KIND_MERGE: begin
                            n_flags = '0;
                            n_state = drtm_pkg::S_MRG_D;
                        end
                        default: n_state = drtm_pkg::S_IDLE;
                    endcase
                end
            end
            drtm_pkg::S_ADD_RD: begin
                if (r_i == r_cnt) begin
                    mem_we = 1'b1;
                    n_res.wake = 1'b1;
                    if (r_cnt < CW'(TABLE_DEPTH)) begin
                        mem_waddr = r_cnt[IW-1:0];
                        mem_wdata = r_c;
                        n_cnt = r_cnt + 1'b1;
                        n_res.status = drtm_pkg::ST_ADDED;
                        n_res.box    = r_c;
                        n_res.slot   = 4'(r_cnt);
                        n_res.total  = 5'(r_cnt + 1'b1);
                    end else begin
                        mem_waddr = '0;
                        mem_wdata = scr_box;
                        n_cnt = CW'(1);
                        n_res.status = drtm_pkg::ST_OVERFLOW;
                        n_res.box    = scr_box;
                        n_res.slot   = '0;
                        n_res.total  = 5'd1;
                    end
                    n_state = drtm_pkg::S_OUT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_i[IW-1:0];
                    n_state   = drtm_pkg::S_ADD_CHK;
                end
            end
            drtm_pkg::S_ADD_CHK: begin
                if (contained) begin
                    n_res.status = drtm_pkg::ST_COVERED;
                    n_res.box    = r_c;
                    n_res.slot   = 4'(r_i);
                    n_state = drtm_pkg::S_OUT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = drtm_pkg::S_ADD_RD;
                end
            end
            drtm_pkg::S_MRG_D: begin
                if (r_d == r_cnt) begin
                    n_i = '0;
                    n_state = drtm_pkg::S_EMIT_S;
                end else if (r_flags[r_d[IW-1:0]]) begin
                    n_d = r_d + 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_d[IW-1:0];
                    n_state   = drtm_pkg::S_MRG_A;
                end
            end
            drtm_pkg::S_MRG_A: begin
                n_a = mem_rdata;
                n_s = '0;
                n_state = drtm_pkg::S_MRG_S;
            end
            drtm_pkg::S_MRG_S: begin
                if (r_s == r_cnt) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_d[IW-1:0];
                    mem_wdata = r_a;
                    n_d = r_d + 1'b1;
                    n_state = drtm_pkg::S_MRG_D;
                end else if (r_flags[r_s[IW-1:0]] || (r_s == r_d)) begin
                    n_s = r_s + 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_s[IW-1:0];
                    n_state   = drtm_pkg::S_MRG_B;
                end
            end
            drtm_pkg::S_MRG_B: begin
                n_state = drtm_pkg::S_MRG_C;
            end
            drtm_pkg::S_MRG_C: begin
                if (r_touch && ({1'b0, r_pj} < ({1'b0, r_pa} + {1'b0, r_pb}))) begin
                    n_a = r_j;
                    n_flags[r_s[IW-1:0]] = 1'b1;
                end
                n_s = r_s + 1'b1;
                n_state = drtm_pkg::S_MRG_S;
            end
            drtm_pkg::S_EMIT_S: begin
                if (r_i == r_cnt) begin
                    n_res.status = drtm_pkg::ST_EMPTY;
                    n_res.last   = 1'b1;
                    n_ret   = drtm_pkg::S_IDLE;
                    n_state = drtm_pkg::S_OUT;
                end else if (r_flags[r_i[IW-1:0]]) begin
                    n_i = r_i + 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_i[IW-1:0];
                    n_state   = drtm_pkg::S_EMIT_D;
                end
            end
            drtm_pkg::S_EMIT_D: begin
                n_res.status = drtm_pkg::ST_SURVIVOR;
                n_res.wake   = 1'b0;
                n_res.box    = mem_rdata;
                n_res.slot   = 4'(r_i);
                n_res.last   = !later;
                n_ret   = later ? drtm_pkg::S_EMIT_S : drtm_pkg::S_IDLE;
                n_i     = r_i + 1'b1;
                n_state = drtm_pkg::S_OUT;
            end
            drtm_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = r_ret;
                end
            end
            default: n_state = drtm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= drtm_pkg::S_IDLE;
            r_ret     <= drtm_pkg::S_IDLE;
            r_cnt     <= '0;
            r_flags   <= '0;
            r_m_valid <= 1'b0;
            r_w       <= 13'd320;
            r_h       <= 13'd240;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_flags <= n_flags;
            if (r_state == drtm_pkg::S_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    drtm_pkg::CFG_WIDTH:  r_w <= i_cfg_data;
                    drtm_pkg::CFG_HEIGHT: r_h <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_d     <= n_d;
        r_s     <= n_s;
        r_a     <= n_a;
        r_c     <= n_c;
        r_res   <= n_res;
        r_j     <= n_j;
        r_touch <= n_touch;
        r_pj    <= n_pj;
        r_pa    <= n_pa;
        r_pb    <= n_pb;
        if (r_state == drtm_pkg::S_OUT && out_free) begin
            r_m <= r_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_m.status;
    assign o_m_axis_tlast  = r_m.last;
    assign o_m_axis_tdata  = {6'b0, r_m.total, r_m.slot, r_m.box.b, r_m.box.r,
                              r_m.box.t, r_m.box.l, r_m.wake};

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re && (mem_waddr == mem_raddr)))
        else $error("RAM read and write of one entry in one cycle");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tuser == drtm_pkg::KIND_CLEAR) |=> (r_cnt == '0) && (r_flags == '0))
        else $error("clear did not empty the table");

    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drtm_pkg::S_MRG_B) |-> (!r_flags[r_s[IW-1:0]] && (r_s != r_d)))
        else $error("merge compared an absorbed entry or itself");
endmodule
